@@ design/mft_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the motor feedback turn tracker.
// No dependencies; imported by every module of the block.
package mft_pkg;

  localparam int CNT_W = 16;
  localparam int ID_W = 11;
  // Degrees within one turn: at most 65535*360/256, so 17 bits for any legal range.
  localparam int DEG_W = 17;
  localparam int ANG_W = 32;

  localparam logic [ID_W-1:0] FEEDBACK_ID_RESET = 11'd513;
  localparam logic [ANG_W-1:0] DEG_PER_TURN = 32'd360;

  typedef enum logic {
    REQ_FRAME = 1'b0,
    REQ_ZERO  = 1'b1
  } req_e;

  // Decoded item handed from the input stage to the unwrap stage.
  typedef struct packed {
    logic             zero_req;
    logic             match;
    logic [CNT_W-1:0] count;
    logic [15:0]      speed;
    logic [15:0]      current;
    logic [7:0]       temp;
    logic [DEG_W-1:0] deg;
  } frm_t;

endpackage

@@ design/mft_decode.sv @@
`timescale 1ns / 1ps
// Input stage: frame filter, field extraction and count-to-degree scaling.
// Depends on mft_pkg.
module mft_decode
  import mft_pkg::*;
#(
  parameter int ENCODER_RANGE = 8192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  input  logic [ID_W-1:0]  frame_std_id_i,
  input  logic             frame_is_standard_i,
  input  logic [63:0]      frame_data_i,
  input  logic [ID_W-1:0]  feedback_id_i,
  output logic             frm_valid_o,
  input  logic             frm_take_i,
  output frm_t             frm_o
);

  // floor(c*360/R) == (c*DegMul) >> ShiftW for every 16-bit c, with 2^ShiftW >= 2^16*R.
  localparam int RangeLog = $clog2(ENCODER_RANGE);
  localparam int ShiftW = CNT_W + RangeLog;
  localparam logic [63:0] DegMul =
    ((64'd360 << ShiftW) + 64'(ENCODER_RANGE) - 64'd1) / 64'(ENCODER_RANGE);
  localparam int ProdW = ShiftW + DEG_W;

  logic             valid_q, valid_d;
  frm_t             frm_q, frm_d;
  logic [ProdW-1:0] prod;
  logic             accept;

  assign in_ready_o = !valid_q || frm_take_i;
  assign accept = in_valid_i && in_ready_o;
  assign valid_d = accept || (valid_q && !frm_take_i);

  always_comb begin
    frm_d.zero_req = (req_e'(req_type_i) == REQ_ZERO);
    frm_d.match = (req_e'(req_type_i) == REQ_FRAME) && frame_is_standard_i &&
                  (frame_std_id_i == feedback_id_i);
    frm_d.count = frame_data_i[63:48];
    frm_d.speed = frame_data_i[47:32];
    frm_d.current = frame_data_i[31:16];
    frm_d.temp = frame_data_i[15:8];
    prod = ProdW'(frm_d.count) * ProdW'(DegMul);
    frm_d.deg = prod[ShiftW +: DEG_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frm_q <= frm_d;
    end
  end

  assign frm_valid_o = valid_q;
  assign frm_o = frm_q;

endmodule

@@ design/mft_unwrap.sv @@
`timescale 1ns / 1ps
// Measurement state, turn unwrap, angle rebuild and the result register.
// Depends on mft_pkg.
module mft_unwrap
  import mft_pkg::*;
#(
  parameter int ENCODER_RANGE = 8192
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    frm_valid_i,
  output logic                    frm_take_o,
  input  frm_t                    frm_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    accepted_o,
  output logic [CNT_W-1:0]        encoder_count_o,
  output logic signed [15:0]      rotor_speed_o,
  output logic signed [15:0]      drive_current_o,
  output logic [7:0]              temperature_o,
  output logic signed [ANG_W-1:0] turn_count_o,
  output logic signed [ANG_W-1:0] total_angle_deg_o,
  output logic                    feedback_seen_o
);

  localparam logic signed [CNT_W+1:0] Half = (CNT_W+2)'(ENCODER_RANGE / 2);

  // Architectural state. turns360_q tracks turns_q*360 so the angle needs only adds.
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      speed_q, speed_d;
  logic [15:0]      current_q, current_d;
  logic [7:0]       temp_q, temp_d;
  logic [ANG_W-1:0] turns_q, turns_d;
  logic [ANG_W-1:0] turns360_q, turns360_d;
  logic [ANG_W-1:0] angle_q, angle_d;
  logic             seen_q, seen_d;

  logic             out_valid_q;
  logic             res_accepted_q;
  logic [CNT_W-1:0] res_count_q;
  logic [15:0]      res_speed_q, res_current_q;
  logic [7:0]       res_temp_q;
  logic [ANG_W-1:0] res_turns_q, res_angle_q;
  logic             res_seen_q;

  logic                    take;
  logic                    first_frame;
  logic signed [CNT_W+1:0] delta;

  assign take = frm_valid_i && (!out_valid_q || out_ready_i);
  assign frm_take_o = take;

  always_comb begin
    count_d = count_q;
    speed_d = speed_q;
    current_d = current_q;
    temp_d = temp_q;
    turns_d = turns_q;
    turns360_d = turns360_q;
    angle_d = angle_q;
    seen_d = seen_q;
    first_frame = (count_q == '0) && (turns_q == '0) && (angle_q == '0);
    delta = $signed({2'b00, frm_i.count}) - $signed({2'b00, count_q});
    if (frm_i.zero_req) begin
      turns_d = '0;
      turns360_d = '0;
      angle_d = '0;
    end else if (frm_i.match) begin
      count_d = frm_i.count;
      speed_d = frm_i.speed;
      current_d = frm_i.current;
      temp_d = frm_i.temp;
      seen_d = 1'b1;
      if (first_frame) begin
        angle_d = ANG_W'(frm_i.deg);
      end else begin
        priority if (delta > Half) begin
          turns_d = turns_q - 1'b1;
          turns360_d = turns360_q - DEG_PER_TURN;
        end else if (delta < -Half) begin
          turns_d = turns_q + 1'b1;
          turns360_d = turns360_q + DEG_PER_TURN;
        end else begin
          turns_d = turns_q;
          turns360_d = turns360_q;
        end
        angle_d = turns360_d + ANG_W'(frm_i.deg);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      speed_q <= '0;
      current_q <= '0;
      temp_q <= '0;
      turns_q <= '0;
      turns360_q <= '0;
      angle_q <= '0;
      seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q <= count_d;
        speed_q <= speed_d;
        current_q <= current_d;
        temp_q <= temp_d;
        turns_q <= turns_d;
        turns360_q <= turns360_d;
        angle_q <= angle_d;
        seen_q <= seen_d;
      end
      out_valid_q <= take || (out_valid_q && !out_ready_i);
    end
  end

  // The result register reports the state as it stands after the item.
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_accepted_q <= frm_i.match;
      res_count_q <= count_d;
      res_speed_q <= speed_d;
      res_current_q <= current_d;
      res_temp_q <= temp_d;
      res_turns_q <= turns_d;
      res_angle_q <= angle_d;
      res_seen_q <= seen_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o = res_accepted_q;
  assign encoder_count_o = res_count_q;
  assign rotor_speed_o = $signed(res_speed_q);
  assign drive_current_o = $signed(res_current_q);
  assign temperature_o = res_temp_q;
  assign turn_count_o = $signed(res_turns_q);
  assign total_angle_deg_o = $signed(res_angle_q);
  assign feedback_seen_o = res_seen_q;

`ifndef SYNTHESIS
  a_turns360_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    turns360_q == ANG_W'(turns_q * DEG_PER_TURN))
    else $error("turns360_q out of step with turns_q");

  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && frm_i.zero_req |=> turns_q == '0 && angle_q == '0)
    else $error("zero request did not clear turns and angle");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(turns_q) && $stable(angle_q) && $stable(count_q))
    else $error("state changed without an item");

  a_accept_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_accepted_q |-> res_seen_q)
    else $error("accepted item without feedback_seen");
`endif

endmodule

@@ design/motor_feedback_turn_tracker.sv @@
`timescale 1ns / 1ps
// Motor feedback turn tracker. Takes one item per clock while out_ready_i is high;
// each item gives one result, through the input register, then the result register,
// and a full pipeline sustains one item per cycle. The feedback ID register may only be
// written while no item is in flight. Depends on mft_pkg, mft_decode and mft_unwrap.
module motor_feedback_turn_tracker
  import mft_pkg::*;
#(
  parameter int ENCODER_RANGE = 8192
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [ID_W-1:0]         cfg_feedback_id_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    req_type_i,
  input  logic [ID_W-1:0]         frame_std_id_i,
  input  logic                    frame_is_standard_i,
  input  logic [63:0]             frame_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    accepted_o,
  output logic [CNT_W-1:0]        encoder_count_o,
  output logic signed [15:0]      rotor_speed_o,
  output logic signed [15:0]      drive_current_o,
  output logic [7:0]              temperature_o,
  output logic signed [ANG_W-1:0] turn_count_o,
  output logic signed [ANG_W-1:0] total_angle_deg_o,
  output logic                    feedback_seen_o
);

  logic [ID_W-1:0] feedback_id_q;
  logic            frm_valid;
  logic            frm_take;
  frm_t            frm;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feedback_id_q <= FEEDBACK_ID_RESET;
    end else if (cfg_valid_i) begin
      feedback_id_q <= cfg_feedback_id_i;
    end
  end

  mft_decode #(
    .ENCODER_RANGE(ENCODER_RANGE)
  ) u_decode (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .frame_std_id_i     (frame_std_id_i),
    .frame_is_standard_i(frame_is_standard_i),
    .frame_data_i       (frame_data_i),
    .feedback_id_i      (feedback_id_q),
    .frm_valid_o        (frm_valid),
    .frm_take_i         (frm_take),
    .frm_o              (frm)
  );

  mft_unwrap #(
    .ENCODER_RANGE(ENCODER_RANGE)
  ) u_unwrap (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frm_valid_i      (frm_valid),
    .frm_take_o       (frm_take),
    .frm_i            (frm),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accepted_o       (accepted_o),
    .encoder_count_o  (encoder_count_o),
    .rotor_speed_o    (rotor_speed_o),
    .drive_current_o  (drive_current_o),
    .temperature_o    (temperature_o),
    .turn_count_o     (turn_count_o),
    .total_angle_deg_o(total_angle_deg_o),
    .feedback_seen_o  (feedback_seen_o)
  );

endmodule

@@ test/motor_feedback_turn_tracker_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for motor_feedback_turn_tracker: a directed table, then random
// items under several feedback IDs, each result compared with a typed row or the bench tracker.
// Depends on mft_pkg and the design sources of the block.
module motor_feedback_turn_tracker_tb;
  import mft_pkg::*;

  localparam int ENC_RANGE = 8192;
  localparam int PIPE_LAT = 2;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIR_N = 20;
  localparam int ID_PLANS = 6;
  localparam int ITEMS_PER_ID = 305;

  typedef struct packed {
    logic                    accepted;
    logic [CNT_W-1:0]        count;
    logic signed [15:0]      speed;
    logic signed [15:0]      current;
    logic [7:0]              temp;
    logic signed [ANG_W-1:0] turns;
    logic signed [ANG_W-1:0] angle;
    logic                    seen;
  } fb_result_t;

  typedef struct {
    logic [CNT_W-1:0] count_now;
    logic [CNT_W-1:0] count_prev;
    logic [15:0]      speed;
    logic [15:0]      current;
    logic [7:0]       temp;
    logic [ANG_W-1:0] turns;
    logic [ANG_W-1:0] angle;
    logic             seen;
  } tracker_state_t;

  typedef struct {
    req_e       req;
    logic [10:0] id;
    logic       std;
    logic [63:0] data;
    bit         typed;
    fb_result_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [ID_W-1:0] cfg_feedback_id_i;
  logic in_valid_i;
  logic in_ready_o;
  logic req_type_i;
  logic [ID_W-1:0] frame_std_id_i;
  logic frame_is_standard_i;
  logic [63:0] frame_data_i;
  logic out_valid_o;
  logic out_ready_i;
  logic accepted_o;
  logic [CNT_W-1:0] encoder_count_o;
  logic signed [15:0] rotor_speed_o;
  logic signed [15:0] drive_current_o;
  logic [7:0] temperature_o;
  logic signed [ANG_W-1:0] turn_count_o;
  logic signed [ANG_W-1:0] total_angle_deg_o;
  logic feedback_seen_o;

  motor_feedback_turn_tracker #(
    .ENCODER_RANGE(ENC_RANGE)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_feedback_id_i  (cfg_feedback_id_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .frame_std_id_i     (frame_std_id_i),
    .frame_is_standard_i(frame_is_standard_i),
    .frame_data_i       (frame_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .accepted_o         (accepted_o),
    .encoder_count_o    (encoder_count_o),
    .rotor_speed_o      (rotor_speed_o),
    .drive_current_o    (drive_current_o),
    .temperature_o      (temperature_o),
    .turn_count_o       (turn_count_o),
    .total_angle_deg_o  (total_angle_deg_o),
    .feedback_seen_o    (feedback_seen_o)
  );

  tracker_state_t trk;
  logic [ID_W-1:0] fid_model;
  fb_result_t pending_q[$];
  dir_row_t dir_tab[DIR_N];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned items_sent;
  int unsigned frames_taken;
  int unsigned turn_steps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("motor_feedback_turn_tracker verification failed");
      $finish;
    end
  end

  // Most gaps are short, a few are long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Turn tracker: updates trk and returns the result the block should report.
  function automatic fb_result_t track_item(input logic req, input logic [10:0] id,
                                            input logic std, input logic [63:0] data);
    fb_result_t res;
    logic [ANG_W-1:0] deg;
    int delta;
    res = '0;
    if (req == REQ_ZERO) begin
      trk.turns = '0;
      trk.angle = '0;
    end else if (std && id == fid_model) begin
      trk.count_prev = trk.count_now;
      trk.count_now = data[63:48];
      trk.speed = data[47:32];
      trk.current = data[31:16];
      trk.temp = data[15:8];
      deg = (32'(trk.count_now) * DEG_PER_TURN) / ENC_RANGE;
      // With nothing tracked yet the turn count is left alone.
      if (trk.count_prev == '0 && trk.turns == '0 && trk.angle == '0) begin
        trk.angle = deg;
      end else begin
        delta = int'(trk.count_now) - int'(trk.count_prev);
        if (delta > ENC_RANGE / 2) begin
          trk.turns = trk.turns - 1;
          turn_steps++;
        end else if (delta < -(ENC_RANGE / 2)) begin
          trk.turns = trk.turns + 1;
          turn_steps++;
        end
        trk.angle = trk.turns * DEG_PER_TURN + deg;
      end
      trk.seen = 1'b1;
      res.accepted = 1'b1;
      frames_taken++;
    end
    res.count = trk.count_now;
    res.speed = trk.speed;
    res.current = trk.current;
    res.temp = trk.temp;
    res.turns = trk.turns;
    res.angle = trk.angle;
    res.seen = trk.seen;
    return res;
  endfunction

  // Called right after a rising edge; returns right after the edge that ends the gap.
  task automatic push_item(input logic req, input logic [10:0] id, input logic std,
                           input logic [63:0] data, input bit no_gap, input bit typed,
                           input fb_result_t want);
    fb_result_t res;
    int unsigned gap;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    frame_std_id_i <= id;
    frame_is_standard_i <= std;
    frame_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    res = track_item(req, id, std, data);
    pending_q.push_back(typed ? want : res);
    items_sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_feedback_id(input logic [ID_W-1:0] fid);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (PIPE_LAT + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_feedback_id_i <= fid;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    fid_model = fid;
  endtask

  // Mostly well-formed feedback with counts that walk, wrap and jump; the rest is noise.
  task automatic push_random(input bit no_gap);
    logic req;
    logic [10:0] id;
    logic std;
    logic [63:0] data;
    logic [CNT_W-1:0] cnt;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    req = REQ_FRAME;
    id = fid_model;
    std = 1'b1;
    data = {$urandom, $urandom};
    if (r < 70) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        cnt = trk.count_now + 16'($urandom_range(0, 600)) - 16'd300;
        cnt = 16'(cnt % ENC_RANGE);
      end else if (k < 80) begin
        // Step more than half a turn ahead, modulo the range; the unwrap fires unless the step wraps.
        cnt = 16'((trk.count_now + ENC_RANGE / 2 + 1 +
                   $urandom_range(0, ENC_RANGE / 2 - 2)) % ENC_RANGE);
      end else if (k < 85) begin
        cnt = trk.count_now + ((k & 1) ? 16'(ENC_RANGE / 2) : -16'(ENC_RANGE / 2));
      end else if (k < 92) begin
        cnt = '0;
      end else begin
        cnt = 16'($urandom);
      end
      data[63:48] = cnt;
    end else if (r < 78) begin
      req = REQ_ZERO;
      id = 11'($urandom);
      std = 1'($urandom);
    end else if (r < 86) begin
      id = 11'($urandom);
      if (id == fid_model) id = id ^ (11'd1 << $urandom_range(0, 10));
    end else if (r < 94) begin
      std = 1'b0;
      if ($urandom_range(0, 1)) id = 11'($urandom);
    end else begin
      req = 1'($urandom);
      id = 11'($urandom);
      std = 1'($urandom);
    end
    push_item(req, id, std, data, no_gap, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    fb_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_field("accepted", want.accepted, accepted_o);
        check_field("encoder_count", want.count, encoder_count_o);
        check_field("rotor_speed", $signed(want.speed), rotor_speed_o);
        check_field("drive_current", $signed(want.current), drive_current_o);
        check_field("temperature", want.temp, temperature_o);
        check_field("turn_count", $signed(want.turns), turn_count_o);
        check_field("total_angle_deg", $signed(want.angle), total_angle_deg_o);
        check_field("feedback_seen", want.seen, feedback_seen_o);
      end
    end
  end

  // Receiver: runs of ready, broken by stalls, now and then a long run with none.
  initial begin
    int unsigned run;
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [ID_W-1:0] id_plan[ID_PLANS];
    int unsigned hold_at;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_feedback_id_i = '0;
    in_valid_i = 1'b0;
    req_type_i = 1'b0;
    frame_std_id_i = '0;
    frame_is_standard_i = 1'b0;
    frame_data_i = '0;
    fail_cnt = 0;
    cycle_cnt = 0;
    items_sent = 0;
    frames_taken = 0;
    turn_steps = 0;
    trk = '{default: '0};
    fid_model = FEEDBACK_ID_RESET;

    // Rows with a typed result are read straight off the rules; the rest use the tracker.
    dir_tab = '{
      '{REQ_ZERO,  11'd513,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
      '{REQ_FRAME, 11'd512,  1'b1, 64'h1234_5678_9ABC_DEF0, 1'b1, '0},
      '{REQ_FRAME, 11'd513,  1'b0, 64'h1FFF_7FFF_8000_FF00, 1'b1, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h0000_0000_0000_00AA, 1'b1,
        '{1'b1, 16'h0, 16'sh0, 16'sh0, 8'h0, 32'sd0, 32'sd0, 1'b1}},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h1FFF_7FFF_8000_FF00, 1'b1,
        '{1'b1, 16'h1FFF, 16'sh7FFF, 16'sh8000, 8'hFF, 32'sd0, 32'sd359, 1'b1}},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h0000_8000_7FFF_0001, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h1000_0001_FFFF_3C00, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h0000_FFFF_0001_4000, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h1001_0010_FFF0_2100, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'hFFFF_0000_0000_00FF, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h0000_1234_4321_1000, 1'b0, '0},
      '{REQ_ZERO,  11'd0,    1'b0, 64'hDEAD_BEEF_0123_4567, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h1FFF_0100_FF00_5000, 1'b0, '0},
      '{REQ_FRAME, 11'd2047, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{REQ_FRAME, 11'd0,    1'b0, 64'h0000_0000_0000_0000, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h0005_8001_7FFE_7F00, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h0000_0000_0000_0000, 1'b0, '0},
      '{REQ_ZERO,  11'd513,  1'b1, 64'h1FFF_7FFF_8000_FF00, 1'b0, '0},
      '{REQ_FRAME, 11'd513,  1'b1, 64'h8000_7FFF_8000_0100, 1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs under the reset value of the feedback ID.
    for (int i = 0; i < DIR_N; i++) begin
      push_item(dir_tab[i].req, dir_tab[i].id, dir_tab[i].std, dir_tab[i].data,
                1'b0, dir_tab[i].typed, dir_tab[i].want);
    end

    id_plan[0] = '0;
    id_plan[1] = '1;
    for (int p = 2; p < ID_PLANS; p++) id_plan[p] = 11'($urandom);
    hold_at = $urandom_range(50, ITEMS_PER_ID - 50);

    for (int p = 0; p < ID_PLANS; p++) begin
      write_feedback_id(id_plan[p]);
      for (int n = 0; n < ITEMS_PER_ID; n++) begin
        if (p == 1 && n == hold_at) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
        push_random((n % 150) < 25);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_q.size());
      fail_cnt++;
    end

    $display("Sent %0d items across %0d feedback ID settings plus the reset value.",
             items_sent, ID_PLANS);
    $display("%0d frames taken, %0d turn steps unwrapped, %0d cycles.",
             frames_taken, turn_steps, cycle_cnt);
    if (fail_cnt == 0) begin
      $display("motor_feedback_turn_tracker verification clean");
    end else begin
      $display("motor_feedback_turn_tracker verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/mft_pkg.sv
design/mft_decode.sv
design/mft_unwrap.sv
design/motor_feedback_turn_tracker.sv
test/motor_feedback_turn_tracker_tb.sv
